### rtl/ookd_pkg.sv
package ookd_pkg;

  localparam int unsigned BUFFER_BYTES = 32;
  localparam int unsigned MAX_OUT      = 32;
  localparam int unsigned DUMP_N       = (BUFFER_BYTES < MAX_OUT) ? BUFFER_BYTES : MAX_OUT;
  localparam int unsigned POS_W        = $clog2(BUFFER_BYTES);
  localparam int unsigned HBC_W        = POS_W + 4;
  localparam int unsigned DUMP_W       = $clog2(DUMP_N);
  localparam int unsigned CMDQ_DEPTH   = 2;
  localparam int unsigned CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned PRE_W      = 8;
  localparam int unsigned MB_W       = 6;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WIDTH_W-1:0] SHORT_MIN_RST    = 16'd200;
  localparam logic [WIDTH_W-1:0] LONG_MIN_RST     = 16'd700;
  localparam logic [WIDTH_W-1:0] LONG_MAX_RST     = 16'd1200;
  localparam logic [WIDTH_W-1:0] GAP_MIN_RST      = 16'd2500;
  localparam logic [PRE_W-1:0]   PREAMBLE_MIN_RST = 8'd24;
  localparam logic [MB_W-1:0]    MIN_BYTES_RST    = 6'd8;
  localparam logic [PRE_W-1:0]   PRE_SAT          = 8'hFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SHORT_MIN    = 3'd0,
    CFG_LONG_MIN     = 3'd1,
    CFG_LONG_MAX     = 3'd2,
    CFG_GAP_MIN      = 3'd3,
    CFG_PREAMBLE_MIN = 3'd4,
    CFG_MIN_BYTES    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_DECODE  = 2'd0,
    ST_FAIL    = 2'd1,
    ST_FRAME   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CLS_SHORT = 2'd0,
    CLS_LONG  = 2'd1,
    CLS_GAP   = 2'd2,
    CLS_BAD   = 2'd3
  } cls_e;

  typedef enum logic [3:0] {
    PH_WAIT = 4'b0001,
    PH_HALF = 4'b0010,
    PH_OK   = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    SQ_RUN  = 3'b001,
    SQ_READ = 3'b010,
    SQ_EMIT = 3'b100
  } seq_e;

  typedef struct packed {
    logic [WIDTH_W-1:0] short_min;
    logic [WIDTH_W-1:0] long_min;
    logic [WIDTH_W-1:0] long_max;
    logic [WIDTH_W-1:0] gap_min;
    logic [PRE_W-1:0]   preamble_min;
    logic [MB_W-1:0]    min_bytes;
  } cfg_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] pulse_width;
    logic               start_of_capture;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   byte_index;
    logic [7:0]         data_byte;
    logic [CNT_W-1:0]   bit_count;
    logic               last;
  } res_item_t;

  typedef struct packed {
    cls_e cls;
    logic soc;
  } cmd_t;

endpackage

### rtl/ookd_classify.sv
module ookd_classify (
  input  ookd_pkg::in_item_t item_i,
  input  ookd_pkg::cfg_t     cfg_i,
  output ookd_pkg::cmd_t     cmd_o
);
  import ookd_pkg::*;

  logic is_data;
  logic is_long;
  logic is_gap;

  assign is_data = (item_i.pulse_width >= cfg_i.short_min) &&
                   (item_i.pulse_width < cfg_i.long_max);
  assign is_long = item_i.pulse_width >= cfg_i.long_min;
  assign is_gap  = item_i.pulse_width >= cfg_i.gap_min;

  always_comb begin
    cmd_o.soc = item_i.start_of_capture;
    priority if (is_data && is_long) begin
      cmd_o.cls = CLS_LONG;
    end else if (is_data) begin
      cmd_o.cls = CLS_SHORT;
    end else if (is_gap) begin
      cmd_o.cls = CLS_GAP;
    end else begin
      cmd_o.cls = CLS_BAD;
    end
  end

endmodule

### rtl/ookd_cmdq.sv
module ookd_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  ookd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           vld_o,
  output ookd_pkg::cmd_t cmd_o
);
  import ookd_pkg::*;

  cmd_t                  slot_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wp_q, wp_d;
  logic [CMDQ_PTR_W-1:0] rp_q, rp_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_wr;
  logic                  do_rd;

  assign full_o = cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH);
  assign vld_o  = cnt_q != '0;
  assign cmd_o  = slot_q[rp_q];
  assign do_wr  = wr_i && !full_o;
  assign do_rd  = rd_i && vld_o;

  always_comb begin
    wp_d  = do_wr ? wp_q + 1'b1 : wp_q;
    rp_d  = do_rd ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

endmodule

### rtl/ookd_back.sv
module ookd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ookd_pkg::cfg_t      cfg_i,
  input  logic                cmd_vld_i,
  input  ookd_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                res_vld_o,
  output ookd_pkg::res_item_t res_o,
  input  logic                res_pop_i
);
  import ookd_pkg::*;

  seq_e                    seq_q, seq_d;
  phase_e                  phase_q, phase_d;
  logic [PRE_W-1:0]        pob_q, pob_d;
  logic [HBC_W-1:0]        hbc_q, hbc_d;
  logic [7:0]              cur_q, cur_d;
  logic [BUFFER_BYTES-1:0] valid_q, valid_d;
  logic [DUMP_W-1:0]       dump_q, dump_d;
  res_item_t               res_q, res_d;
  logic                    res_vld_q, res_vld_d;

  logic [7:0]              mem [BUFFER_BYTES];
  logic [7:0]              rd_data_q;
  logic                    rd_hit_q;
  logic                    mem_we;
  logic [POS_W-1:0]        mem_waddr;
  logic [7:0]              mem_wdata;

  // state as seen after an optional start-of-capture clear
  phase_e                  ph_e;
  logic [PRE_W-1:0]        pob_e;
  logic [HBC_W-1:0]        hbc_e;
  logic [7:0]              cur_e;
  logic [BUFFER_BYTES-1:0] valid_e;
  logic [POS_W-1:0]        pos_e;

  logic                    out_free;
  logic                    take;
  status_e                 run_st;
  logic                    do_bit;
  logic                    flip;
  logic [PRE_W-1:0]        pob_n;
  logic [7:0]              cur_sh;
  logic [HBC_W:0]          hbc_inc;
  logic                    dump_last;

  assign out_free  = !res_vld_q || res_pop_i;
  assign take      = (seq_q == SQ_RUN) && cmd_vld_i && out_free;
  assign cmd_pop_o = take;
  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;
  assign dump_last = dump_q == DUMP_W'(DUMP_N - 1);

  always_comb begin
    if (cmd_i.soc) begin
      ph_e    = PH_WAIT;
      pob_e   = '0;
      hbc_e   = '0;
      cur_e   = '0;
      valid_e = '0;
    end else begin
      ph_e    = phase_q;
      pob_e   = pob_q;
      hbc_e   = hbc_q;
      cur_e   = cur_q;
      valid_e = valid_q;
    end
    pos_e = hbc_e[HBC_W-1:4];
  end

  always_comb begin
    seq_d     = seq_q;
    phase_d   = phase_q;
    pob_d     = pob_q;
    hbc_d     = hbc_q;
    cur_d     = cur_q;
    valid_d   = valid_q;
    dump_d    = dump_q;
    res_vld_d = res_vld_q && !res_pop_i;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = pos_e;
    mem_wdata = cur_e;
    run_st    = ST_DECODE;
    do_bit    = 1'b0;
    flip      = 1'b0;
    pob_n     = pob_e;
    cur_sh    = cur_e;
    hbc_inc   = {1'b0, hbc_e} + 1'b1;

    unique case (seq_q)
      SQ_RUN: begin
        if (take) begin
          phase_d = ph_e;
          pob_d   = pob_e;
          hbc_d   = hbc_e;
          cur_d   = cur_e;
          valid_d = valid_e;

          priority if (ph_e == PH_DONE) begin
            run_st = ST_IGNORED;
          end else if (cmd_i.cls == CLS_SHORT || cmd_i.cls == CLS_LONG) begin
            unique case (ph_e)
              PH_WAIT: begin
                if (cmd_i.cls == CLS_LONG) begin
                  pob_d = (pob_e == PRE_SAT) ? pob_e : pob_e + 8'd1;
                end else if (pob_e >= cfg_i.preamble_min) begin
                  pob_d   = '0;
                  phase_d = PH_HALF;
                end else begin
                  run_st = ST_FAIL;
                end
              end
              PH_OK: begin
                if (cmd_i.cls == CLS_LONG) begin
                  do_bit = 1'b1;
                  flip   = 1'b1;
                end else begin
                  phase_d = PH_HALF;
                end
              end
              PH_HALF: begin
                if (cmd_i.cls == CLS_LONG) begin
                  run_st = ST_FAIL;
                end else begin
                  do_bit = 1'b1;
                end
              end
              default: run_st = ST_FAIL;
            endcase
          end else if (cmd_i.cls == CLS_GAP &&
                       {{MB_W{1'b0}}, pos_e} >= {{POS_W{1'b0}}, cfg_i.min_bytes}) begin
            run_st = ST_FRAME;
          end else begin
            run_st = ST_FAIL;
          end

          if (do_bit) begin
            pob_n = pob_e ^ {{(PRE_W-1){1'b0}}, flip};
            pob_d = pob_n;
            // only even half-bits land in the store
            if (!hbc_e[0]) begin
              cur_sh         = {|pob_n, cur_e[7:1]};
              cur_d          = cur_sh;
              mem_we         = 1'b1;
              mem_wdata      = cur_sh;
              valid_d[pos_e] = 1'b1;
            end
            if (hbc_inc[HBC_W]) begin
              run_st = ST_FAIL;
            end else begin
              hbc_d   = hbc_inc[HBC_W-1:0];
              phase_d = PH_OK;
              if (hbc_inc[3:0] == 4'd0) begin
                cur_d = '0;
              end
            end
          end

          if (run_st == ST_FAIL) begin
            phase_d = PH_WAIT;
            pob_d   = '0;
            hbc_d   = '0;
            cur_d   = '0;
            valid_d = '0;
            mem_we  = 1'b0;
          end

          if (run_st == ST_FRAME) begin
            phase_d = PH_DONE;
            dump_d  = '0;
            seq_d   = SQ_READ;
          end else begin
            res_vld_d        = 1'b1;
            res_d.status     = run_st;
            res_d.byte_index = '0;
            res_d.data_byte  = '0;
            res_d.bit_count  = CNT_W'(hbc_d);
            res_d.last       = 1'b1;
          end
        end
      end
      SQ_READ: begin
        seq_d = SQ_EMIT;
      end
      SQ_EMIT: begin
        if (out_free) begin
          res_vld_d        = 1'b1;
          res_d.status     = ST_FRAME;
          res_d.byte_index = IDX_W'(dump_q);
          res_d.data_byte  = rd_hit_q ? rd_data_q : 8'h00;
          res_d.bit_count  = CNT_W'(hbc_q);
          res_d.last       = dump_last;
          if (dump_last) begin
            seq_d = SQ_RUN;
          end else begin
            dump_d = dump_q + 1'b1;
            seq_d  = SQ_READ;
          end
        end
      end
      default: seq_d = SQ_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SQ_RUN;
      phase_q   <= PH_WAIT;
      pob_q     <= '0;
      hbc_q     <= '0;
      cur_q     <= '0;
      valid_q   <= '0;
      dump_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      seq_q     <= seq_d;
      phase_q   <= phase_d;
      pob_q     <= pob_d;
      hbc_q     <= hbc_d;
      cur_q     <= cur_d;
      valid_q   <= valid_d;
      dump_q    <= dump_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (seq_q == SQ_READ) begin
      rd_data_q <= mem[POS_W'(dump_q)];
      rd_hit_q  <= valid_q[POS_W'(dump_q)];
    end
  end

endmodule

### rtl/ook_manchester_pulse_decoder.sv
// On-off keyed pulse decoder with Manchester payload.
// Input side is a queue: drive item_i and raise push; the word is taken on
// a rising edge with push high and full low. Each word is one measured
// pulse width plus a start-of-capture flag that clears the decoder first.
// Result side is a queue too: while empty is low the oldest result sits on
// result_o, and it leaves on a rising edge with pop high.
// Every pulse gives one result, except a frame-completing gap, which gives
// one frame byte result per store byte (32), the final one flagged last.
// A pulse reaches result_o through the command queue and the result register.
// Throughput: one pulse per cycle, while results are popped and no dump runs,
// through a two-word command queue and a decode step; a frame dump reads each
// byte from memory, then loads it into the output register, as pulses queue.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i;
// only write while the block is idle.
// Reset sets the registers to their defaults and clears the decoder; the
// byte store is cleared through per-byte valid bits, so no sweep is needed.
// When pop stays low the output register holds, the decoder stalls and the
// command queue fills until full goes high.
module ook_manchester_pulse_decoder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ookd_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [ookd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                  push,
  output logic                                  full,
  input  ookd_pkg::in_item_t                    item_i,
  output logic                                  empty,
  input  logic                                  pop,
  output ookd_pkg::res_item_t                   result_o
);
  import ookd_pkg::*;

  cfg_t      cfg_q, cfg_d;
  cmd_t      cls_cmd;
  cmd_t      head_cmd;
  logic      head_vld;
  logic      head_pop;
  logic      res_vld;
  res_item_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_SHORT_MIN:    cfg_d.short_min    = cfg_wdata_i;
        CFG_LONG_MIN:     cfg_d.long_min     = cfg_wdata_i;
        CFG_LONG_MAX:     cfg_d.long_max     = cfg_wdata_i;
        CFG_GAP_MIN:      cfg_d.gap_min      = cfg_wdata_i;
        CFG_PREAMBLE_MIN: cfg_d.preamble_min = cfg_wdata_i[PRE_W-1:0];
        CFG_MIN_BYTES:    cfg_d.min_bytes    = cfg_wdata_i[MB_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_min    <= SHORT_MIN_RST;
      cfg_q.long_min     <= LONG_MIN_RST;
      cfg_q.long_max     <= LONG_MAX_RST;
      cfg_q.gap_min      <= GAP_MIN_RST;
      cfg_q.preamble_min <= PREAMBLE_MIN_RST;
      cfg_q.min_bytes    <= MIN_BYTES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ookd_classify u_classify (
    .item_i (item_i),
    .cfg_i  (cfg_q),
    .cmd_o  (cls_cmd)
  );

  ookd_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (push),
    .cmd_i  (cls_cmd),
    .full_o (full),
    .rd_i   (head_pop),
    .vld_o  (head_vld),
    .cmd_o  (head_cmd)
  );

  ookd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .cmd_vld_i (head_vld),
    .cmd_i     (head_cmd),
    .cmd_pop_o (head_pop),
    .res_vld_o (res_vld),
    .res_o     (res),
    .res_pop_i (pop)
  );

  assign empty    = !res_vld;
  assign result_o = res;

  // a frame dump ends exactly on the last store byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status == ST_FRAME && result_o.last) |->
      (result_o.byte_index == IDX_W'(DUMP_N - 1)))
    else $error("frame dump ended on wrong byte");

  // nothing interleaves with a frame dump
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && result_o.status == ST_FRAME && !result_o.last) |=>
      (empty || result_o.status == ST_FRAME))
    else $error("frame dump interrupted");

  // a rejected pulse leaves a cleared half-bit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status == ST_FAIL) |-> (result_o.bit_count == '0))
    else $error("reject with nonzero bit count");

  // the decoder never takes a command while the dump runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status == ST_FRAME && !result_o.last) |-> !head_pop)
    else $error("command taken during frame dump");

endmodule

### test/tb_ook_manchester_pulse_decoder.sv
module tb_ook_manchester_pulse_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import ookd_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int REPORT_MAX  = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  push;
  logic                  full;
  in_item_t              item_i;
  logic                  empty;
  logic                  pop;
  res_item_t             result_o;

  ook_manchester_pulse_decoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // decoder shadow state, updated as each pulse word is taken
  cfg_t             dec_cfg;
  phase_e           dec_phase;
  logic [PRE_W-1:0] dec_pre_bit;
  logic [9:0]       dec_half_bits;
  logic [7:0]       dec_store [BUFFER_BYTES];

  res_item_t pending_results [$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int cycle_count;
  int error_count;
  int pulses_sent;
  int results_checked;
  int frames_done;
  int overflows;

  function automatic void clear_decoder_state();
    dec_phase     = PH_WAIT;
    dec_pre_bit   = '0;
    dec_half_bits = '0;
    for (int i = 0; i < BUFFER_BYTES; i++) dec_store[i] = '0;
  endfunction

  function automatic void reset_decoder_model();
    dec_cfg.short_min    = SHORT_MIN_RST;
    dec_cfg.long_min     = LONG_MIN_RST;
    dec_cfg.long_max     = LONG_MAX_RST;
    dec_cfg.gap_min      = GAP_MIN_RST;
    dec_cfg.preamble_min = PREAMBLE_MIN_RST;
    dec_cfg.min_bytes    = MIN_BYTES_RST;
    clear_decoder_state();
  endfunction

  // only even half-bits land in the store; overflow clears everything
  function automatic bit absorb_half_bit(logic b);
    logic [IDX_W-1:0] at;
    at = dec_half_bits[8:4];
    if (!dec_half_bits[0]) dec_store[at] = {b, dec_store[at][7:1]};
    dec_half_bits = dec_half_bits + 10'd1;
    if (dec_half_bits[9:4] >= BUFFER_BYTES) begin
      clear_decoder_state();
      overflows++;
      return 1'b0;
    end
    dec_phase = PH_OK;
    return 1'b1;
  endfunction

  function automatic bit manchester_half(logic flip);
    dec_pre_bit = dec_pre_bit ^ {7'd0, flip};
    return absorb_half_bit(dec_pre_bit != '0);
  endfunction

  function automatic status_e decode_width(logic [WIDTH_W-1:0] w);
    logic is_long;
    if (dec_cfg.short_min <= w && w < dec_cfg.long_max) begin
      is_long = (w >= dec_cfg.long_min);
      case (dec_phase)
        PH_WAIT: begin
          if (is_long) begin
            if (dec_pre_bit != PRE_SAT) dec_pre_bit = dec_pre_bit + 8'd1;
          end else if (dec_pre_bit >= dec_cfg.preamble_min) begin
            dec_pre_bit = '0;
            dec_phase   = PH_HALF;
          end else begin
            return ST_FAIL;
          end
          return ST_DECODE;
        end
        PH_OK: begin
          if (!is_long) begin
            dec_phase = PH_HALF;
            return ST_DECODE;
          end
          return manchester_half(1'b1) ? ST_DECODE : ST_FAIL;
        end
        default: begin
          if (!is_long) return manchester_half(1'b0) ? ST_DECODE : ST_FAIL;
          return ST_FAIL;
        end
      endcase
    end
    if (w >= dec_cfg.gap_min && dec_half_bits[9:4] >= dec_cfg.min_bytes) return ST_FRAME;
    return ST_FAIL;
  endfunction

  function automatic void queue_result(status_e st, logic [IDX_W-1:0] idx, logic [7:0] data,
                                       logic is_last);
    res_item_t r;
    r.status     = st;
    r.byte_index = idx;
    r.data_byte  = data;
    r.bit_count  = dec_half_bits[CNT_W-1:0];
    r.last       = is_last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_pulse(logic [WIDTH_W-1:0] w, logic soc);
    status_e st;
    if (soc) clear_decoder_state();
    if (dec_phase == PH_DONE) begin
      queue_result(ST_IGNORED, '0, '0, 1'b1);
      return;
    end
    st = decode_width(w);
    if (st == ST_FAIL) clear_decoder_state();
    if (st != ST_FRAME) begin
      queue_result(st, '0, '0, 1'b1);
      return;
    end
    dec_phase = PH_DONE;
    frames_done++;
    for (int k = 0; k < DUMP_N; k++)
      queue_result(ST_FRAME, k[IDX_W-1:0], dec_store[k], k == DUMP_N - 1);
  endfunction

  function automatic logic [WIDTH_W-1:0] rand_short();
    return WIDTH_W'($urandom_range(dec_cfg.long_min - 1, dec_cfg.short_min));
  endfunction

  function automatic logic [WIDTH_W-1:0] rand_long();
    return WIDTH_W'($urandom_range(dec_cfg.long_max - 1, dec_cfg.long_min));
  endfunction

  function automatic logic [WIDTH_W-1:0] rand_gap();
    return WIDTH_W'($urandom_range(16'hFFFF, dec_cfg.gap_min));
  endfunction

  // result side: random pop, compare each taken word with the oldest prediction
  always @(negedge clk_i) begin
    pop = rst_ni && ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    res_item_t want;
    if (rst_ni && pop && !empty) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("[%0t] unexpected word: status %0d idx %0d byte %02h count %0d last %0d",
                   $realtime, result_o.status, result_o.byte_index, result_o.data_byte,
                   result_o.bit_count, result_o.last);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status || result_o.byte_index !== want.byte_index ||
            result_o.data_byte !== want.data_byte || result_o.bit_count !== want.bit_count ||
            result_o.last !== want.last) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("[%0t] mismatch: expected status %0d idx %0d byte %02h count %0d last %0d",
                     $realtime, want.status, want.byte_index, want.data_byte,
                     want.bit_count, want.last);
            $display("              got      status %0d idx %0d byte %02h count %0d last %0d",
                     result_o.status, result_o.byte_index, result_o.data_byte,
                     result_o.bit_count, result_o.last);
          end
        end
      end
    end
  end

  task automatic send_pulse(logic [WIDTH_W-1:0] w, logic soc);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push                   = 1'b1;
    item_i.pulse_width      = w;
    item_i.start_of_capture = soc;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_pulse(w, soc);
    pulses_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    case (idx)
      CFG_SHORT_MIN:    dec_cfg.short_min    = val;
      CFG_LONG_MIN:     dec_cfg.long_min     = val;
      CFG_LONG_MAX:     dec_cfg.long_max     = val;
      CFG_GAP_MIN:      dec_cfg.gap_min      = val;
      CFG_PREAMBLE_MIN: dec_cfg.preamble_min = val[PRE_W-1:0];
      CFG_MIN_BYTES:    dec_cfg.min_bytes    = val[MB_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_config(int sm, int lmin, int lmax, int gmin, int pmin, int mb);
    wait_drained();
    // let the decoder settle before touching the registers
    repeat (8) @(negedge clk_i);
    write_reg(CFG_SHORT_MIN, CFG_DATA_W'(sm));
    write_reg(CFG_LONG_MIN, CFG_DATA_W'(lmin));
    write_reg(CFG_LONG_MAX, CFG_DATA_W'(lmax));
    write_reg(CFG_GAP_MIN, CFG_DATA_W'(gmin));
    write_reg(CFG_PREAMBLE_MIN, CFG_DATA_W'(pmin));
    write_reg(CFG_MIN_BYTES, CFG_DATA_W'(mb));
  endtask

  // n preamble longs then the start short; soc rides on the first pulse
  task automatic send_preamble(int n, logic soc);
    for (int i = 0; i < n; i++) send_pulse(rand_long(), soc && i == 0);
    send_pulse(rand_short(), soc && n == 0);
  endtask

  // expects the decoder right after the start pulse
  task automatic send_half_bits(int n);
    bit in_half;
    in_half = 1'b1;
    repeat (n) begin
      if (in_half) begin
        send_pulse(rand_short(), 1'b0);
        in_half = 1'b0;
      end else if ($urandom_range(1)) begin
        send_pulse(rand_long(), 1'b0);
      end else begin
        send_pulse(rand_short(), 1'b0);
        send_pulse(rand_short(), 1'b0);
      end
    end
  endtask

  task automatic test_thresholds();
    send_pulse(16'd0, 1'b0);
    send_pulse(16'hFFFF, 1'b0);
    send_pulse(16'd199, 1'b0);
    send_pulse(16'd200, 1'b0);   // short with no preamble
    send_pulse(16'd699, 1'b0);
    send_pulse(16'd700, 1'b0);
    send_pulse(16'd1199, 1'b0);
    send_pulse(16'd1200, 1'b0);  // above data range, below gap
    send_pulse(16'd700, 1'b0);
    send_pulse(16'd2499, 1'b0);
    send_pulse(16'd2500, 1'b0);  // gap but too few bytes
    send_pulse(16'd1000, 1'b0);
    send_pulse(16'd1000, 1'b1);
    send_pulse(16'hAAAA, 1'b1);
    send_pulse(16'h5555, 1'b0);
  endtask

  task automatic test_empty_frame();
    set_config(200, 700, 1200, 2500, 0, 0);
    send_pulse(16'd3000, 1'b1);  // gap completes an empty frame
    send_pulse(16'd300, 1'b0);
    send_pulse(16'hFFFF, 1'b0);
    send_pulse(16'd300, 1'b1);
    send_pulse(16'd800, 1'b0);   // long right after the first short
    send_pulse(16'd300, 1'b0);
    send_pulse(16'd300, 1'b0);
    send_pulse(16'd900, 1'b0);
    send_pulse(16'd300, 1'b0);
    send_pulse(16'd300, 1'b0);
    send_pulse(16'd2500, 1'b0);
    send_pulse(16'd200, 1'b0);
  endtask

  task automatic test_preamble_saturation();
    set_config(200, 700, 1200, 2500, 255, 0);
    send_pulse(rand_long(), 1'b1);
    repeat (260) send_pulse(rand_long(), 1'b0);
    send_pulse(rand_short(), 1'b0);
    send_half_bits(3);
    send_pulse(rand_gap(), 1'b0);
  endtask

  task automatic test_config_extremes();
    set_config(0, 0, 0, 0, 0, 0);
    send_pulse(16'd0, 1'b1);
    send_pulse(16'hFFFF, 1'b0);
    send_pulse(WIDTH_W'($urandom_range(16'hFFFF)), 1'b1);
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 32);
    send_pulse(16'hFFFF, 1'b0);
    send_pulse(16'd0, 1'b0);
    send_pulse(16'h8000, 1'b1);
    set_config(0, 16'h8000, 16'hFFFF, 16'hFFFF, 0, 0);
    send_pulse(16'd0, 1'b1);
    send_pulse(16'd1, 1'b0);
    send_pulse(16'hFFFE, 1'b0);
    send_pulse(16'h7FFF, 1'b0);
    send_pulse(16'h8000, 1'b0);
    send_pulse(16'd0, 1'b0);
    send_pulse(16'd0, 1'b0);
    send_pulse(16'hFFFF, 1'b0);
    send_pulse(16'd0, 1'b0);
  endtask

  task automatic test_store_overflow();
    set_config(200, 700, 1200, 2500, 24, 8);
    // one half-bit short of overflow, then a full dump
    send_preamble(24, 1'b1);
    send_half_bits(511);
    send_pulse(rand_gap(), 1'b0);
    // now run past the end of the store
    send_preamble(24, 1'b1);
    send_pulse(rand_short(), 1'b0);
    repeat (513) send_pulse(rand_long(), 1'b0);
  endtask

  task automatic test_random_traffic(int n_items);
    int  goal;
    int  choice;
    int  pre_n;
    int  sm;
    int  lmin;
    int  lmax;
    bit  paused;
    goal   = pulses_sent + n_items;
    paused = 1'b0;
    sm     = $urandom_range(300, 50);
    lmin   = sm + $urandom_range(600, 100);
    lmax   = lmin + $urandom_range(800, 100);
    set_config(sm, lmin, lmax, lmax + $urandom_range(2000), $urandom_range(6),
               $urandom_range(1));
    while (pulses_sent < goal) begin
      if (!paused && pulses_sent >= goal - n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      choice = $urandom_range(99);
      pre_n  = dec_cfg.preamble_min + $urandom_range(3);
      if (choice < 70) begin
        send_preamble(pre_n, dec_phase == PH_DONE || $urandom_range(3) == 0);
        send_half_bits($urandom_range(24) +
                       (($urandom_range(4) == 0) ? 0 : dec_cfg.min_bytes * 16));
        send_pulse(rand_gap(), 1'b0);
      end else if (choice < 80) begin
        send_preamble(pre_n, 1'b1);
        send_half_bits($urandom_range(12));
        if ($urandom_range(1)) begin
          send_pulse(rand_short(), 1'b0);
          send_pulse(rand_long(), 1'b0);
        end else begin
          send_pulse(WIDTH_W'($urandom_range(dec_cfg.short_min - 1)), 1'b0);
        end
      end else begin
        send_pulse(WIDTH_W'($urandom_range(16'hFFFF)), $urandom_range(4) == 0);
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycle_count,
             pending_results.size());
    $display("** ook_manchester_pulse_decoder: FAILED **");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = '0;
    cfg_wdata_i     = '0;
    push            = 1'b0;
    item_i          = '0;
    pop             = 1'b0;
    snd_idle_pct    = 11;
    rcv_idle_pct    = 77;
    error_count     = 0;
    pulses_sent     = 0;
    results_checked = 0;
    frames_done     = 0;
    overflows       = 0;
    reset_decoder_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_thresholds();
    test_empty_frame();
    test_preamble_saturation();
    test_random_traffic(95);

    snd_idle_pct = 77;
    rcv_idle_pct = 11;
    test_config_extremes();
    test_store_overflow();
    test_random_traffic(95);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(95);

    wait_drained();
    repeat (20) @(negedge clk_i);

    $display("run covered %0d pulses, %0d result words, %0d frame dumps, %0d store overflows",
             pulses_sent, results_checked, frames_done, overflows);
    $display("idle mixes send/receive 11/77, 77/11 and 0/0; %0d errors, %0d words left over",
             error_count, pending_results.size());
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("** ook_manchester_pulse_decoder: PASSED **");
    end else begin
      $display("** ook_manchester_pulse_decoder: FAILED **");
    end
    $finish;
  end

endmodule

### ook_manchester_pulse_decoder.f
rtl/ookd_pkg.sv
rtl/ookd_classify.sv
rtl/ookd_cmdq.sv
rtl/ookd_back.sv
rtl/ook_manchester_pulse_decoder.sv
test/tb_ook_manchester_pulse_decoder.sv
